// ===== sv/cgc_pkg.sv =====
// Shared types, constants and helpers for the Caesar / Gronsfeld byte cipher.
package cgc_pkg;

  localparam int CHAR_W      = 8;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 64;
  localparam int SHIFT_W     = 5;   // reduced shift, 0..25
  localparam int LEN_W       = 5;   // raw key length register
  localparam int DIGIT_W     = 4;
  localparam int CAESAR_W    = 6;   // signed Caesar shift register

  localparam logic [5:0]        ALPHA_LEN   = 6'd26;
  localparam logic signed [6:0] ALPHA_LEN_S = 7'sd26;

  localparam logic [CHAR_W-1:0] CH_LOWER_A = 8'h61;
  localparam logic [CHAR_W-1:0] CH_LOWER_Z = 8'h7a;
  localparam logic [CHAR_W-1:0] CH_UPPER_A = 8'h41;
  localparam logic [CHAR_W-1:0] CH_UPPER_Z = 8'h5a;

  localparam logic [CAESAR_W-1:0] CAESAR_RESET = 6'd3;
  localparam logic [LEN_W-1:0]    LENGTH_RESET = 5'd1;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_CIPHER_SELECT = 3'd0,
    REG_CAESAR_SHIFT  = 3'd1,
    REG_KEY_NEGATE    = 3'd2,
    REG_KEY_LENGTH    = 3'd3,
    REG_KEY_DIGITS    = 3'd4
  } cfg_reg_t;

  // Signed 6-bit shift reduced to 0..25 (true modulo).
  function automatic logic [SHIFT_W-1:0] caesar_mod26(input logic [CAESAR_W-1:0] s);
    logic signed [6:0] r;
    r = $signed({s[CAESAR_W-1], s});
    if (r < 0) begin
      r = r + ALPHA_LEN_S;
      if (r < 0) begin
        r = r + ALPHA_LEN_S;
      end
    end else if (r >= ALPHA_LEN_S) begin
      r = r - ALPHA_LEN_S;
    end
    return r[SHIFT_W-1:0];
  endfunction

  // Gronsfeld digit, optionally negated, reduced to 0..25.
  function automatic logic [SHIFT_W-1:0] digit_shift(input logic [DIGIT_W-1:0] d,
                                                     input logic neg);
    logic [SHIFT_W-1:0] r;
    if (neg && (d != '0)) begin
      r = ALPHA_LEN[SHIFT_W-1:0] - {1'b0, d};
    end else begin
      r = {1'b0, d};
    end
    return r;
  endfunction

endpackage

// ===== sv/caesar_gronsfeld_cipher.sv =====
// Caesar / Gronsfeld byte-stream cipher: config registers, key pointer, two-stage pipe.
//
// A byte accepted on s_* reaches m_* through the stage 1 register and the result register.
// Throughput: one byte per cycle unless the output stalls; the only loop is the key digit pointer, updated at accept.
// s_tready drops only when both pipeline stages hold data and m_tready is low.
// Reset (rst, synchronous, active high): Caesar mode, shift 3, add digits, key length 1,
// all digits 0, key pointer at the first digit, pipeline empty.
module caesar_gronsfeld_cipher #(
  parameter int KEY_DIGITS = 16
) (
  input  logic                               clk,
  input  logic                               rst,
  // config write channel
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [cgc_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [cgc_pkg::CFG_DATA_W-1:0]     cfg_data,
  // input byte stream
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [cgc_pkg::CHAR_W-1:0]         s_tdata,   // [7:0] in_char
  // output byte stream
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [cgc_pkg::CHAR_W-1:0]         m_tdata    // [7:0] out_char
);

  localparam int POS_W = (KEY_DIGITS > 1) ? $clog2(KEY_DIGITS) : 1;
  localparam logic [cgc_pkg::LEN_W-1:0] MAX_LEN = cgc_pkg::LEN_W'(KEY_DIGITS);

  // ---------------------------------------------------------------------------
  // Configuration registers. Any write to a defined index restarts the key.
  // ---------------------------------------------------------------------------
  logic                                              cipher_select;
  logic [cgc_pkg::CAESAR_W-1:0]                      caesar_shift;
  logic                                              key_negate;
  logic [cgc_pkg::LEN_W-1:0]                         key_length;
  logic [KEY_DIGITS-1:0][cgc_pkg::DIGIT_W-1:0]       key_digits;
  logic                                              cfg_hit;

  assign cfg_ready = 1'b1;
  assign cfg_hit   = cfg_valid && (cfg_index <= cgc_pkg::REG_KEY_DIGITS);

  always_ff @(posedge clk) begin
    if (rst) begin
      cipher_select <= 1'b0;
      caesar_shift  <= cgc_pkg::CAESAR_RESET;
      key_negate    <= 1'b0;
      key_length    <= cgc_pkg::LENGTH_RESET;
      key_digits    <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        cgc_pkg::REG_CIPHER_SELECT: cipher_select <= cfg_data[0];
        cgc_pkg::REG_CAESAR_SHIFT:  caesar_shift  <= cfg_data[cgc_pkg::CAESAR_W-1:0];
        cgc_pkg::REG_KEY_NEGATE:    key_negate    <= cfg_data[0];
        cgc_pkg::REG_KEY_LENGTH:    key_length    <= cfg_data[cgc_pkg::LEN_W-1:0];
        cgc_pkg::REG_KEY_DIGITS:    key_digits    <= cfg_data[KEY_DIGITS*cgc_pkg::DIGIT_W-1:0];
        default: ;  // undefined index: ignored, no key restart
      endcase
    end
  end

  // Effective key length: 0 acts as 1, anything above the digit count is clamped.
  logic [cgc_pkg::LEN_W-1:0] eff_len;
  always_comb begin
    if (key_length == '0) begin
      eff_len = cgc_pkg::LENGTH_RESET;
    end else if (key_length > MAX_LEN) begin
      eff_len = MAX_LEN;
    end else begin
      eff_len = key_length;
    end
  end

  // ---------------------------------------------------------------------------
  // Pipeline handshake: stage 1 feeds the result register.
  // ---------------------------------------------------------------------------
  logic s1_valid;
  logic out_adv;
  logic s1_adv;
  logic in_xact;

  assign out_adv  = !m_tvalid || m_tready;
  assign s1_adv   = !s1_valid || out_adv;
  assign s_tready = s1_adv;
  assign in_xact  = s_tvalid && s_tready;

  // Letter classification of the incoming byte.
  logic in_lower;
  logic in_upper;
  logic in_letter;
  assign in_lower  = (s_tdata >= cgc_pkg::CH_LOWER_A) && (s_tdata <= cgc_pkg::CH_LOWER_Z);
  assign in_upper  = (s_tdata >= cgc_pkg::CH_UPPER_A) && (s_tdata <= cgc_pkg::CH_UPPER_Z);
  assign in_letter = in_lower || in_upper;

  // ---------------------------------------------------------------------------
  // Key digit pointer. It always stays below eff_len: it is cleared on every
  // defined-index config write (the only way eff_len changes) and wraps at eff_len.
  // ---------------------------------------------------------------------------
  logic [POS_W-1:0]           key_pos;
  logic [POS_W-1:0]           key_pos_next;
  logic [cgc_pkg::LEN_W-1:0]  pos_inc;

  assign pos_inc = cgc_pkg::LEN_W'(key_pos) + 1'b1;

  always_comb begin
    key_pos_next = key_pos;
    if (cfg_hit) begin
      key_pos_next = '0;
    end else if (in_xact && in_letter && cipher_select) begin
      key_pos_next = (pos_inc == eff_len) ? '0 : pos_inc[POS_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      key_pos <= '0;
    end else begin
      key_pos <= key_pos_next;
    end
  end

  // Shift for this byte, reduced to 0..25.
  logic [cgc_pkg::SHIFT_W-1:0] in_shift;
  always_comb begin
    if (cipher_select) begin
      in_shift = cgc_pkg::digit_shift(key_digits[key_pos], key_negate);
    end else begin
      in_shift = cgc_pkg::caesar_mod26(caesar_shift);
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: byte, class and shift.
  // ---------------------------------------------------------------------------
  logic [cgc_pkg::CHAR_W-1:0]  s1_char;
  logic                        s1_letter;
  logic                        s1_lower;
  logic [cgc_pkg::SHIFT_W-1:0] s1_shift;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_adv) begin
      s1_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xact) begin
      s1_char   <= s_tdata;
      s1_letter <= in_letter;
      s1_lower  <= in_lower;
      s1_shift  <= in_shift;
    end
  end

  // Rotate within the alphabet, keeping case.
  logic [cgc_pkg::CHAR_W-1:0] s1_base;
  logic [cgc_pkg::CHAR_W-1:0] s1_off;
  logic [5:0]                 s1_sum;
  logic [5:0]                 s1_idx;
  logic [cgc_pkg::CHAR_W-1:0] s1_result;

  always_comb begin
    s1_base = s1_lower ? cgc_pkg::CH_LOWER_A : cgc_pkg::CH_UPPER_A;
    s1_off  = s1_char - s1_base;
    s1_sum  = {1'b0, s1_off[cgc_pkg::SHIFT_W-1:0]} + {1'b0, s1_shift};
    s1_idx  = (s1_sum >= cgc_pkg::ALPHA_LEN) ? (s1_sum - cgc_pkg::ALPHA_LEN) : s1_sum;
    s1_result = s1_letter ? (s1_base + cgc_pkg::CHAR_W'(s1_idx)) : s1_char;
  end

  // ---------------------------------------------------------------------------
  // Result register.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_adv) begin
      m_tvalid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_adv && s1_valid) begin
      m_tdata <= s1_result;
    end
  end

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_pos_in_range: assert property (@(posedge clk) disable iff (rst)
    cgc_pkg::LEN_W'(key_pos) < eff_len)
    else $error("key pointer at or beyond key length");

  a_cfg_restart: assert property (@(posedge clk) disable iff (rst)
    cfg_hit |=> (key_pos == '0))
    else $error("key pointer not restarted after config write");

  a_shift_range: assert property (@(posedge clk) disable iff (rst)
    s1_valid |-> (s1_shift < cgc_pkg::SHIFT_W'(cgc_pkg::ALPHA_LEN)))
    else $error("stage 1 shift out of 0..25");

  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> (s1_valid && m_tvalid && !m_tready))
    else $error("input stalled with room in the pipeline");

endmodule

// ===== test/caesar_gronsfeld_cipher_tb.sv =====
// Self-checking regression bench for the Caesar / Gronsfeld byte-stream cipher.
`timescale 1ns / 1ps

module caesar_gronsfeld_cipher_tb;

  localparam int CLK_PERIOD     = 4;
  localparam int RESET_CYCLES   = 7;
  localparam int KEY_COUNT      = 16;
  localparam int PHASES         = 10;
  localparam int PHASE_ITEMS    = 70;
  localparam int DRAIN_CYCLES   = 4;        // two-stage pipe, plus margin
  localparam int TIMEOUT_CYCLES = 500_000;
  localparam int ALPHABET       = int'(cgc_pkg::ALPHA_LEN);

  // Index past the register list: decoded as a no-op by the block.
  localparam logic [cgc_pkg::CFG_INDEX_W-1:0] REG_UNUSED =
    cgc_pkg::CFG_INDEX_W'(cgc_pkg::REG_KEY_DIGITS) + 1'b1;

  // Expected-output tracker: shadow copy of the config registers and the digit pointer,
  // predicts each ciphered byte at input accept and checks outputs in order.
  class cipher_scoreboard #(int KEYS = 16);
    bit                             gronsfeld;
    logic [cgc_pkg::CAESAR_W-1:0]   caesar;
    bit                             negate;
    logic [cgc_pkg::LEN_W-1:0]      key_len;
    logic [cgc_pkg::CFG_DATA_W-1:0] digits;
    int                             key_pos;
    logic [cgc_pkg::CHAR_W-1:0]     expected_chars[$];
    int                             errors;

    function void reset_state();
      gronsfeld = 1'b0;
      caesar    = cgc_pkg::CAESAR_RESET;
      negate    = 1'b0;
      key_len   = cgc_pkg::LENGTH_RESET;
      digits    = '0;
      key_pos   = 0;
      expected_chars.delete();
      errors    = 0;
    endfunction

    function void write_reg(logic [cgc_pkg::CFG_INDEX_W-1:0] idx,
                            logic [cgc_pkg::CFG_DATA_W-1:0] val);
      case (idx)
        cgc_pkg::REG_CIPHER_SELECT: gronsfeld = val[0];
        cgc_pkg::REG_CAESAR_SHIFT:  caesar    = val[cgc_pkg::CAESAR_W-1:0];
        cgc_pkg::REG_KEY_NEGATE:    negate    = val[0];
        cgc_pkg::REG_KEY_LENGTH:    key_len   = val[cgc_pkg::LEN_W-1:0];
        cgc_pkg::REG_KEY_DIGITS:    digits    = val;
        default:                    return;  // unknown index: no restart either
      endcase
      key_pos = 0;
    endfunction

    function logic [cgc_pkg::CHAR_W-1:0] encipher(logic [cgc_pkg::CHAR_W-1:0] c);
      int base;
      int len;
      int s;
      if (c >= cgc_pkg::CH_LOWER_A && c <= cgc_pkg::CH_LOWER_Z) begin
        base = int'(cgc_pkg::CH_LOWER_A);
      end else if (c >= cgc_pkg::CH_UPPER_A && c <= cgc_pkg::CH_UPPER_Z) begin
        base = int'(cgc_pkg::CH_UPPER_A);
      end else begin
        return c;
      end
      if (gronsfeld) begin
        len = int'(key_len);
        if (len == 0) len = 1;
        if (len > KEYS) len = KEYS;
        key_pos = key_pos % len;
        s = int'(digits[cgc_pkg::DIGIT_W*key_pos +: cgc_pkg::DIGIT_W]);
        if (negate) s = -s;
        key_pos = (key_pos + 1) % len;
      end else begin
        s = $signed(caesar);
      end
      s = s % ALPHABET;
      if (s < 0) s += ALPHABET;
      return cgc_pkg::CHAR_W'((int'(c) - base + s) % ALPHABET + base);
    endfunction

    function void note_input(logic [cgc_pkg::CHAR_W-1:0] c);
      expected_chars.push_back(encipher(c));
    endfunction

    function void check_result(logic [cgc_pkg::CHAR_W-1:0] got);
      logic [cgc_pkg::CHAR_W-1:0] want;
      if (expected_chars.size() == 0) begin
        $display("%0t: unexpected out_char: expected none, actual %h", $time, got);
        errors++;
        return;
      end
      want = expected_chars.pop_front();
      if (got !== want) begin
        $display("%0t: out_char mismatch: expected %h, actual %h", $time, want, got);
        errors++;
      end
    endfunction
  endclass

  logic                            clk;
  logic                            rst;
  logic                            cfg_valid;
  logic                            cfg_ready;
  logic [cgc_pkg::CFG_INDEX_W-1:0] cfg_index;
  logic [cgc_pkg::CFG_DATA_W-1:0]  cfg_data;
  logic                            s_tvalid;
  logic                            s_tready;
  logic [cgc_pkg::CHAR_W-1:0]      s_tdata;   // [7:0] in_char
  logic                            m_tvalid;
  logic                            m_tready;
  logic [cgc_pkg::CHAR_W-1:0]      m_tdata;   // [7:0] out_char

  cipher_scoreboard #(KEY_COUNT) sb;

  bit no_idle;     // set for stretches where neither side stalls
  int stall_left;

  caesar_gronsfeld_cipher #(.KEY_DIGITS(KEY_COUNT)) uut (
    .clk      (clk),
    .rst      (rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial clk = 1'b0;
  always #(CLK_PERIOD / 2.0) clk = ~clk;

  // Gap length: mostly none, often short, now and then long.
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 20);
  endfunction

  // Monitor: every transaction is observed at the rising edge, before the block's
  // registers move, so the sampled values are the ones the block acted on.
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_valid && cfg_ready) sb.write_reg(cfg_index, cfg_data);
      if (s_tvalid && s_tready)   sb.note_input(s_tdata);
      if (m_tvalid && m_tready)   sb.check_result(m_tdata);
    end
  end

  // Output side back-pressure; one nonblocking write per falling edge.
  always @(negedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (stall_left > 0) begin
      m_tready <= 1'b0;
      stall_left--;
    end else begin
      m_tready <= 1'b1;
      if (!no_idle && $urandom_range(0, 3) == 0) stall_left = gap_len();
    end
  end

  // All driver tasks start and end at a falling edge.
  // send_char leaves s_tvalid high so back-to-back bytes never drop it in between.
  task automatic send_char(input logic [cgc_pkg::CHAR_W-1:0] c);
    s_tvalid <= 1'b1;
    s_tdata  <= c;
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
  endtask

  task automatic send_gapped(input logic [cgc_pkg::CHAR_W-1:0] c);
    int gap;
    send_char(c);
    gap = no_idle ? 0 : gap_len();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic send_text(input string txt);
    for (int i = 0; i < txt.len(); i++) send_char(txt[i]);
  endtask

  // Stop the sender and wait until every predicted byte has come out.
  task automatic drain();
    s_tvalid <= 1'b0;
    while (sb.expected_chars.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // Config write; callers drain first so the pipe is empty.
  // cfg_valid goes low after each write is taken, before the next one starts.
  task automatic write_cfg(input logic [cgc_pkg::CFG_INDEX_W-1:0] idx,
                           input logic [cgc_pkg::CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  // Random data above the register's own bits, to check the field is masked.
  function automatic logic [cgc_pkg::CFG_DATA_W-1:0] noisy(
      input logic [cgc_pkg::CFG_DATA_W-1:0] val, input int width);
    logic [cgc_pkg::CFG_DATA_W-1:0] mask;
    mask = (64'd1 << width) - 64'd1;
    return ({$urandom, $urandom} & ~mask) | (val & mask);
  endfunction

  task automatic random_config(input bit write_all);
    logic [cgc_pkg::CFG_DATA_W-1:0] d;
    int sel;
    if (write_all || $urandom_range(0, 1)) begin
      sel = $urandom_range(0, 5);
      case (sel)
        0: d = 64'(-25);
        1: d = 64'd25;
        2: d = 64'(-32);   // outside -25..25
        3: d = 64'd31;
        default: d = 64'($urandom);
      endcase
      write_cfg(cgc_pkg::REG_CAESAR_SHIFT, noisy(d, cgc_pkg::CAESAR_W));
    end
    if (write_all || $urandom_range(0, 1))
      write_cfg(cgc_pkg::REG_KEY_NEGATE, noisy(64'($urandom_range(0, 1)), 1));
    if (write_all || $urandom_range(0, 1)) begin
      sel = $urandom_range(0, 7);
      case (sel)
        0: d = 64'd1;
        1: d = 64'(KEY_COUNT);
        2: d = 64'd0;      // acts as one digit
        3: d = 64'd31;     // clamps to the full key
        4: d = 64'($urandom_range(17, 31));
        default: d = 64'($urandom_range(1, KEY_COUNT));
      endcase
      write_cfg(cgc_pkg::REG_KEY_LENGTH, noisy(d, cgc_pkg::LEN_W));
    end
    if (write_all || $urandom_range(0, 1)) begin
      sel = $urandom_range(0, 5);
      case (sel)
        0: d = '0;
        1: d = '1;          // every digit fifteen
        2: d = {$urandom, $urandom};
        default: begin
          for (int i = 0; i < KEY_COUNT; i++)
            d[cgc_pkg::DIGIT_W*i +: cgc_pkg::DIGIT_W] =
              cgc_pkg::DIGIT_W'($urandom_range(0, 9));
        end
      endcase
      write_cfg(cgc_pkg::REG_KEY_DIGITS, d);
    end
    if (write_all || $urandom_range(0, 1))
      write_cfg(cgc_pkg::REG_CIPHER_SELECT, noisy(64'($urandom_range(0, 3) != 0), 1));
    if ($urandom_range(0, 4) == 0)
      write_cfg(REG_UNUSED + cgc_pkg::CFG_INDEX_W'($urandom_range(0, 2)),
                {$urandom, $urandom});
  endtask

  // Letters are what move the key pointer, so weight the stream toward them.
  function automatic logic [cgc_pkg::CHAR_W-1:0] random_char();
    int r;
    r = $urandom_range(0, 9);
    if (r < 3)
      return cgc_pkg::CH_UPPER_A + cgc_pkg::CHAR_W'($urandom_range(0, ALPHABET - 1));
    if (r < 6)
      return cgc_pkg::CH_LOWER_A + cgc_pkg::CHAR_W'($urandom_range(0, ALPHABET - 1));
    return cgc_pkg::CHAR_W'($urandom);
  endfunction

  initial begin
    sb = new();
    sb.reset_state();
    rst        = 1'b1;
    cfg_valid  = 1'b0;
    cfg_index  = '0;
    cfg_data   = '0;
    s_tvalid   = 1'b0;
    s_tdata    = '0;
    m_tready   = 1'b0;
    no_idle    = 1'b1;
    stall_left = 0;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Reset settings: Caesar +3. Letter boundaries, their neighbors, byte extremes.
    send_text("AZaz@[`{");
    send_char(8'h00);
    send_char(8'hFF);
    drain();

    // Caesar shift -25, then shifts outside the nominal range (+31 and -32).
    write_cfg(cgc_pkg::REG_CAESAR_SHIFT, 64'(-25));
    send_text("aZ");
    drain();
    write_cfg(cgc_pkg::REG_CAESAR_SHIFT, 64'd31);
    send_text("y");
    drain();
    write_cfg(cgc_pkg::REG_CAESAR_SHIFT, 64'(-32));
    send_text("B");
    drain();

    // Gronsfeld with digits 0, 9, 10, 15; non-letters must not advance the pointer.
    write_cfg(cgc_pkg::REG_KEY_DIGITS, 64'h0000_0000_0000_FA90);
    write_cfg(cgc_pkg::REG_KEY_LENGTH, 64'd4);
    write_cfg(cgc_pkg::REG_KEY_NEGATE, 64'd0);
    write_cfg(cgc_pkg::REG_CIPHER_SELECT, 64'd1);
    send_text("ab-cdZ");
    drain();

    // Decrypt with a zero key length; a write past the register list keeps the pointer.
    write_cfg(cgc_pkg::REG_KEY_NEGATE, 64'd1);
    write_cfg(cgc_pkg::REG_KEY_LENGTH, 64'd0);
    send_text("aZ");
    drain();
    write_cfg(REG_UNUSED, 64'd0);
    send_text("b");
    drain();

    // Key length above the digit count clamps to the full key.
    write_cfg(cgc_pkg::REG_KEY_DIGITS, 64'h1234_5678_9ABC_DEF1);
    write_cfg(cgc_pkg::REG_KEY_LENGTH, 64'd31);
    send_text("zA");
    drain();

    // Random phases: all settings on the first, a random subset on later ones, idling on some, none on others.
    for (int phase = 0; phase < PHASES; phase++) begin
      random_config(phase == 0);
      no_idle = (phase % 3 == 2) || ($urandom_range(0, 3) == 0);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        send_gapped(random_char());
        // Hold the sender off mid-phase until the output side has caught up.
        if (phase % 4 == 1 && i == PHASE_ITEMS / 2) drain();
      end
      drain();
    end

    if (sb.errors == 0 && sb.expected_chars.size() == 0) begin
      $display("caesar_gronsfeld_cipher regression: pass");
    end else begin
      if (sb.expected_chars.size() != 0)
        $display("%0t: %0d out_char values never arrived: expected %h, actual none",
                 $time, sb.expected_chars.size(), sb.expected_chars[0]);
      $display("caesar_gronsfeld_cipher regression: fail");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #(TIMEOUT_CYCLES * CLK_PERIOD);
    $display("caesar_gronsfeld_cipher regression: fail");
    $finish;
  end

endmodule

// ===== caesar_gronsfeld_cipher.f =====
sv/cgc_pkg.sv
sv/caesar_gronsfeld_cipher.sv
test/caesar_gronsfeld_cipher_tb.sv
